// File: rtl/gtg_pkg.sv
`default_nettype none
package gtg_pkg;

  // Datapath widths of the CORDIC row
  localparam int XW = 35;
  localparam int ZW = 34;
  localparam int DEFAULT_CORDIC_STAGES = 16;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 23;

  localparam logic [29:0] INV_GAIN_Q30 = 30'd652032874;
  localparam logic [27:0] BAM_TO_Q13 = 28'd210828714;
  localparam logic signed [17:0] PI_Q13 = 18'sd25736;
  localparam logic signed [17:0] TWO_PI_Q13 = 18'sd51472;
  localparam logic signed [ZW-1:0] QUARTER_TURN = ZW'(64'sd1073741824);

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ALIGN_DIST = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ARRIVE_DIST = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ARRIVE_ANGLE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_SPEED = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_SPEED = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_TURN = 3'd5;

  // Register reset values
  localparam logic [22:0] RST_ALIGN_DIST = 23'd410;
  localparam logic [22:0] RST_ARRIVE_DIST = 23'd614;
  localparam logic [14:0] RST_ARRIVE_ANGLE = 15'd1229;
  localparam logic [12:0] RST_MIN_SPEED = 13'd819;
  localparam logic [12:0] RST_MAX_SPEED = 13'd2458;
  localparam logic [14:0] RST_MAX_TURN = 15'd8192;

  // atan(2^-i), full turn = 2^32
  localparam logic [29:0] ATAN_BAM [32] = '{
    30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756, 30'd42667331,
    30'd21354465, 30'd10679838, 30'd5340245, 30'd2670163, 30'd1335087,
    30'd667544, 30'd333772, 30'd166886, 30'd83443, 30'd41722, 30'd20861,
    30'd10430, 30'd5215, 30'd2608, 30'd1304, 30'd652, 30'd326, 30'd163,
    30'd81, 30'd41, 30'd20, 30'd10, 30'd5, 30'd3, 30'd1, 30'd1, 30'd0
  };

  typedef struct packed {
    logic signed [23:0] goal_x;
    logic signed [23:0] goal_y;
    logic signed [15:0] goal_yaw;
  } in_t;

  typedef struct packed {
    logic [12:0]        linear_speed;
    logic signed [15:0] angular_speed;
    logic               arrived;
  } out_t;

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
    logic signed [23:0]   gx;
    logic signed [15:0]   yaw;
    logic                 zero;
  } cord_t;

  typedef struct packed {
    logic [22:0] align_distance;
    logic [22:0] arrive_distance;
    logic [14:0] arrive_angle;
    logic [12:0] min_speed;
    logic [12:0] max_speed;
    logic [14:0] max_turn;
  } cfg_t;

  // Fold an angle back into [-pi, pi] with one correction
  function automatic logic signed [17:0] wrap_q13(input logic signed [17:0] a);
    logic signed [17:0] r;
    r = a;
    if (r > PI_Q13) r = r - TWO_PI_Q13;
    if (r < -PI_Q13) r = r + TWO_PI_Q13;
    return r;
  endfunction

endpackage
`default_nettype wire

// File: rtl/gtg_cell.sv
`default_nettype none
module gtg_cell #(
  parameter int SHIFT = 0
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          up_vld,
  input  wire gtg_pkg::cord_t up_data,
  output      logic          up_ok,
  output      logic          dn_vld,
  output      gtg_pkg::cord_t dn_data,
  input  wire logic          dn_ok
);
  import gtg_pkg::*;

  logic                 vld_r;
  cord_t                data_r;
  cord_t                data_nxt;
  logic signed [XW-1:0] x_in;
  logic signed [XW-1:0] y_in;
  logic signed [XW-1:0] xs;
  logic signed [XW-1:0] ys;
  logic signed [ZW-1:0] step;

  assign x_in = up_data.x;
  assign y_in = up_data.y;
  assign xs = x_in >>> SHIFT;
  assign ys = y_in >>> SHIFT;
  assign step = $signed({{(ZW-30){1'b0}}, ATAN_BAM[SHIFT]});

  // Rotate toward the x axis, direction from the sign of y
  always_comb begin
    data_nxt = up_data;
    if (!y_in[XW-1]) begin
      data_nxt.x = x_in + ys;
      data_nxt.y = y_in - xs;
      data_nxt.z = up_data.z + step;
    end else begin
      data_nxt.x = x_in - ys;
      data_nxt.y = y_in + xs;
      data_nxt.z = up_data.z - step;
    end
  end

  assign up_ok = !vld_r || dn_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (up_ok) begin
      vld_r <= up_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ok && up_vld) begin
      data_r <= data_nxt;
    end
  end

  assign dn_vld = vld_r;
  assign dn_data = data_r;

endmodule
`default_nettype wire

// File: rtl/gtg_post.sv
`default_nettype none
module gtg_post (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           up_vld,
  input  wire gtg_pkg::cord_t up_data,
  output      logic           up_ok,
  input  wire gtg_pkg::cfg_t  cfg,
  output      logic           out_valid,
  input  wire logic           out_ready,
  output      gtg_pkg::out_t  out_data
);
  import gtg_pkg::*;

  // Stage A: gain and angle-scale products
  logic               vld_a_r;
  logic [62:0]        prod_d_r;
  logic [60:0]        prod_b_r;
  logic               zneg_r;
  logic signed [23:0] gx_r;
  logic signed [15:0] yaw_r;
  logic               ok_b;

  logic [32:0]        x_pos;
  logic [ZW-1:0]      z_abs;
  logic [32:0]        z_mag;

  // Stage B: output register
  logic               out_vld_r;
  out_t               out_r;
  out_t               out_nxt;

  assign z_abs = up_data.z[ZW-1] ? ZW'(-up_data.z) : ZW'(up_data.z);
  assign x_pos = (up_data.x[XW-1] || up_data.zero) ? 33'd0 : up_data.x[32:0];
  assign z_mag = up_data.zero ? 33'd0 : z_abs[32:0];

  assign ok_b = !out_vld_r || out_ready;
  assign up_ok = !vld_a_r || ok_b;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r <= 1'b0;
    end else if (up_ok) begin
      vld_a_r <= up_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ok && up_vld) begin
      prod_d_r <= x_pos * INV_GAIN_Q30;
      prod_b_r <= z_mag * BAM_TO_Q13;
      zneg_r   <= up_data.z[ZW-1];
      gx_r     <= up_data.gx;
      yaw_r    <= up_data.yaw;
    end
  end

  always_comb begin
    logic [63:0]        sum_d;
    logic [61:0]        sum_b;
    logic [25:0]        dist_q;
    logic [15:0]        mag;
    logic signed [17:0] bear;
    logic signed [17:0] yaw18;
    logic [16:0]        ayaw;
    logic signed [24:0] lin;
    logic signed [17:0] ang;
    logic signed [17:0] mt;
    sum_d = {1'b0, prod_d_r} + (64'd1 << 37);
    sum_b = {1'b0, prod_b_r} + (62'd1 << 43);
    dist_q = sum_d[63:38];
    mag   = sum_b[59:44];
    bear  = zneg_r ? -$signed({2'b00, mag}) : $signed({2'b00, mag});
    yaw18 = 18'(yaw_r);
    ayaw  = yaw_r[15] ? 17'(-yaw18) : 17'(yaw18);
    mt    = $signed({3'b000, cfg.max_turn});
    lin   = '0;
    ang   = '0;
    out_nxt = '0;
    if (ayaw < {2'b00, cfg.arrive_angle} && dist_q < {3'b000, cfg.arrive_distance}) begin
      out_nxt.arrived = 1'b1;
    end else if (dist_q < {3'b000, cfg.align_distance}) begin
      out_nxt.angular_speed = 16'(wrap_q13(yaw18));
    end else begin
      lin = {gx_r, 1'b0};
      if (lin < $signed({12'd0, cfg.min_speed})) lin = $signed({12'd0, cfg.min_speed});
      if (lin > $signed({12'd0, cfg.max_speed})) lin = $signed({12'd0, cfg.max_speed});
      ang = wrap_q13(bear);
      if (ang < -mt) ang = -mt;
      if (ang > mt) ang = mt;
      out_nxt.linear_speed  = lin[12:0];
      out_nxt.angular_speed = 16'(ang);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (ok_b) begin
      out_vld_r <= vld_a_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ok_b && vld_a_r) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data = out_r;

endmodule
`default_nettype wire

// File: rtl/go_to_goal_velocity_controller.sv
`default_nettype none
// Channel | Ports                              | Transfer
// input   | in_valid, in_ready, in_data        | in_valid & in_ready
// result  | out_valid, out_ready, out_data     | out_valid & out_ready
// config  | cfg_wr_en, cfg_index, cfg_wdata    | cfg_wr_en
//
// One pose per cycle unless the output stalls; a pose passes one cell per
// CORDIC iteration, a multiply stage, then the output register.
// Reset is synchronous, active low; it clears all valid bits and loads the
// register defaults. A stalled output holds; stages behind it keep filling
// empty slots, so in_ready drops only once every stage holds a pose.
module go_to_goal_velocity_controller #(
  parameter int CORDIC_STAGES = gtg_pkg::DEFAULT_CORDIC_STAGES
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output      logic                             in_ready,
  input  wire gtg_pkg::in_t                     in_data,
  output      logic                             out_valid,
  input  wire logic                             out_ready,
  output      gtg_pkg::out_t                    out_data,
  input  wire logic                             cfg_wr_en,
  input  wire logic [gtg_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [gtg_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import gtg_pkg::*;

  cfg_t  cfg_r;
  cfg_t  cfg_nxt;

  logic  c_vld  [CORDIC_STAGES+1];
  cord_t c_data [CORDIC_STAGES+1];
  logic  c_ok   [CORDIC_STAGES+1];

  logic signed [XW-1:0] xp;
  logic signed [XW-1:0] yp;
  cord_t                pre;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      case (cfg_index)
        REG_ALIGN_DIST:   cfg_nxt.align_distance  = cfg_wdata[22:0];
        REG_ARRIVE_DIST:  cfg_nxt.arrive_distance = cfg_wdata[22:0];
        REG_ARRIVE_ANGLE: cfg_nxt.arrive_angle    = cfg_wdata[14:0];
        REG_MIN_SPEED:    cfg_nxt.min_speed       = cfg_wdata[12:0];
        REG_MAX_SPEED:    cfg_nxt.max_speed       = cfg_wdata[12:0];
        REG_MAX_TURN:     cfg_nxt.max_turn        = cfg_wdata[14:0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.align_distance  <= RST_ALIGN_DIST;
      cfg_r.arrive_distance <= RST_ARRIVE_DIST;
      cfg_r.arrive_angle    <= RST_ARRIVE_ANGLE;
      cfg_r.min_speed       <= RST_MIN_SPEED;
      cfg_r.max_speed       <= RST_MAX_SPEED;
      cfg_r.max_turn        <= RST_MAX_TURN;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Prescale, then fold the left half plane into the right by a quarter turn
  assign xp = $signed({{(XW-32){in_data.goal_x[23]}}, in_data.goal_x, 8'd0});
  assign yp = $signed({{(XW-32){in_data.goal_y[23]}}, in_data.goal_y, 8'd0});

  always_comb begin
    pre.x    = xp;
    pre.y    = yp;
    pre.z    = '0;
    pre.gx   = in_data.goal_x;
    pre.yaw  = in_data.goal_yaw;
    pre.zero = (in_data.goal_x == 24'sd0) && (in_data.goal_y == 24'sd0);
    if (xp[XW-1]) begin
      if (!yp[XW-1]) begin
        pre.x = yp;
        pre.y = -xp;
        pre.z = QUARTER_TURN;
      end else begin
        pre.x = -yp;
        pre.y = xp;
        pre.z = -QUARTER_TURN;
      end
    end
  end

  assign c_vld[0]  = in_valid;
  assign c_data[0] = pre;
  assign in_ready  = c_ok[0];

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
    gtg_cell #(
      .SHIFT(i)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .up_vld  (c_vld[i]),
      .up_data (c_data[i]),
      .up_ok   (c_ok[i]),
      .dn_vld  (c_vld[i+1]),
      .dn_data (c_data[i+1]),
      .dn_ok   (c_ok[i+1])
    );
  end

  gtg_post u_post (
    .clk       (clk),
    .rst_n     (rst_n),
    .up_vld    (c_vld[CORDIC_STAGES]),
    .up_data   (c_data[CORDIC_STAGES]),
    .up_ok     (c_ok[CORDIC_STAGES]),
    .cfg       (cfg_r),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // An empty output register must leave the whole row open
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with an empty output register");

  a_arrived_stops: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.arrived |->
      (out_data.linear_speed == 13'd0) && (out_data.angular_speed == 16'sd0))
    else $error("arrived with nonzero speed");

  a_drive_limits: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.linear_speed != 13'd0) |->
      (out_data.linear_speed <= cfg_r.max_speed) &&
      ($signed({out_data.angular_speed[15], out_data.angular_speed}) <=
       $signed({2'b00, cfg_r.max_turn})) &&
      ($signed({out_data.angular_speed[15], out_data.angular_speed}) >=
       -$signed({2'b00, cfg_r.max_turn})))
    else $error("drive command outside its limits");

endmodule
`default_nettype wire
